@@ rtl/core/recursive_mutex_fifo_handoff_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the recursive mutex lock manager
// Short wrappers for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_MUTEX_FIFO_HANDOFF_MACROS_SVH
`define RECURSIVE_MUTEX_FIFO_HANDOFF_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RMFH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMFH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rmfh_pkg.sv @@
// ----------------------------------------------------------------------------
// rmfh_pkg
// Types and constants of the recursive mutex lock manager.
// ----------------------------------------------------------------------------
package rmfh_pkg;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int TID_W   = 4;
    localparam int STAT_W  = 3;
    localparam int DEPTH_W = 16;

    // Request commands; the fourth code is unused
    typedef enum logic [CMD_W-1:0] {
        CMD_LOCK   = 2'd0,
        CMD_TRY    = 2'd1,
        CMD_UNLOCK = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_BUSY      = 3'd2,
        ST_HELD      = 3'd3,
        ST_RELEASED  = 3'd4,
        ST_NOT_OWNER = 3'd5,
        ST_OVERFLOW  = 3'd6
    } t_status;

endpackage

@@ rtl/core/recursive_mutex_fifo_handoff.sv @@
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_handoff
// Lock manager for one recursive mutex with a FIFO of waiting threads.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake           | beat payload
//  ----------+-----------+---------------------+----------------------------------
//  request   | in        | start && !busy      | i_cmd, i_thread_id
//  result    | out       | o_done (one cycle)  | o_status, o_woken_valid,
//            |           |                     | o_woken_thread, o_lock_depth
//
//  One request per cycle while busy is low; its result passes through the input
//  register, then decision logic into the result register, and then appears on
//  the result ports.
//  The wait queue is a memory of THREADS entries; the entry at the next head
//  is read ahead into a register, with a write bypass.
//  Synchronous reset frees the mutex and empties the queue at once; busy is
//  high during reset and the cycle after it, low otherwise.
//  The result side cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module recursive_mutex_fifo_handoff #(
    parameter int THREADS    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [rmfh_pkg::CMD_W-1:0]       i_cmd,
    input  logic [rmfh_pkg::TID_W-1:0]       i_thread_id,
    output logic                             o_done,
    output logic [rmfh_pkg::STAT_W-1:0]      o_status,
    output logic                             o_woken_valid,
    output logic [rmfh_pkg::TID_W-1:0]       o_woken_thread,
    output logic [rmfh_pkg::DEPTH_W-1:0]     o_lock_depth
);

`include "recursive_mutex_fifo_handoff_macros.svh"

    localparam int QW = $clog2(THREADS);
    localparam int UW = $clog2(THREADS + 1);
    localparam logic [QW-1:0]         LAST_SLOT = QW'(THREADS - 1);
    localparam logic [UW-1:0]         QUEUE_MAX = UW'(THREADS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // Input register
    logic                        r_ready;
    logic                        r_in_valid;
    logic [rmfh_pkg::CMD_W-1:0]  r_cmd;
    logic [rmfh_pkg::TID_W-1:0]  r_tid;

    // Lock state
    logic                        r_held,  n_held;
    logic [rmfh_pkg::TID_W-1:0]  r_owner, n_owner;
    logic [COUNT_BITS-1:0]       r_count, n_count;
    logic [QW-1:0]               r_head,  n_head;
    logic [QW-1:0]               r_tail,  n_tail;
    logic [UW-1:0]               r_used,  n_used;

    // Wait queue storage and prefetched head entry
    logic [rmfh_pkg::TID_W-1:0]  r_queue [THREADS];
    logic [rmfh_pkg::TID_W-1:0]  r_head_q;
    logic                        w_wr_en;

    // Result register
    logic                        r_done;
    rmfh_pkg::t_status           r_status, n_status;
    logic                        r_wvalid, n_wvalid;
    logic [rmfh_pkg::TID_W-1:0]  r_wthread, n_wthread;
    logic [rmfh_pkg::DEPTH_W-1:0] r_depth;

    rmfh_pkg::t_cmd              w_cmd;

    assign busy  = ~r_ready;
    assign w_cmd = rmfh_pkg::t_cmd'(r_cmd);

    // Input capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready    <= 1'b0;
            r_in_valid <= 1'b0;
        end else begin
            r_ready    <= 1'b1;
            r_in_valid <= start & r_ready;
        end
        r_cmd <= i_cmd;
        r_tid <= i_thread_id;
    end

    // Request decision
    always_comb begin
        n_held    = r_held;
        n_owner   = r_owner;
        n_count   = r_count;
        n_head    = r_head;
        n_tail    = r_tail;
        n_used    = r_used;
        w_wr_en   = 1'b0;
        n_status  = rmfh_pkg::ST_NOT_OWNER;
        n_wvalid  = 1'b0;
        n_wthread = '0;
        if (r_in_valid) begin
            case (w_cmd) inside
                rmfh_pkg::CMD_LOCK, rmfh_pkg::CMD_TRY: begin
                    if (r_held && r_owner == r_tid) begin
                        if (r_count == COUNT_MAX) begin
                            n_status = rmfh_pkg::ST_OVERFLOW;
                        end else begin
                            n_count  = r_count + COUNT_ONE;
                            n_status = rmfh_pkg::ST_GRANTED;
                        end
                    end else if (!r_held) begin
                        n_held   = 1'b1;
                        n_owner  = r_tid;
                        n_count  = COUNT_ONE;
                        n_status = rmfh_pkg::ST_GRANTED;
                    end else if (w_cmd == rmfh_pkg::CMD_TRY) begin
                        n_status = rmfh_pkg::ST_BUSY;
                    end else if (r_used == QUEUE_MAX) begin
                        n_status = rmfh_pkg::ST_OVERFLOW;
                    end else begin
                        w_wr_en  = 1'b1;
                        n_tail   = (r_tail == LAST_SLOT) ? '0 : r_tail + QW'(1);
                        n_used   = r_used + UW'(1);
                        n_status = rmfh_pkg::ST_QUEUED;
                    end
                end
                rmfh_pkg::CMD_UNLOCK: begin
                    if (!r_held || r_owner != r_tid) begin
                        n_status = rmfh_pkg::ST_NOT_OWNER;
                    end else if (r_count > COUNT_ONE) begin
                        n_count  = r_count - COUNT_ONE;
                        n_status = rmfh_pkg::ST_HELD;
                    end else if (r_used != '0) begin
                        // hand off to the oldest waiter
                        n_owner   = r_head_q;
                        n_count   = COUNT_ONE;
                        n_head    = (r_head == LAST_SLOT) ? '0 : r_head + QW'(1);
                        n_used    = r_used - UW'(1);
                        n_wvalid  = 1'b1;
                        n_wthread = r_head_q;
                        n_status  = rmfh_pkg::ST_RELEASED;
                    end else begin
                        n_held   = 1'b0;
                        n_owner  = '0;
                        n_count  = '0;
                        n_status = rmfh_pkg::ST_RELEASED;
                    end
                end
                default: begin
                    n_status = rmfh_pkg::ST_NOT_OWNER;
                end
            endcase
        end
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_owner <= '0;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_used  <= '0;
        end else begin
            r_held  <= n_held;
            r_owner <= n_owner;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_used  <= n_used;
        end
    end

    // Wait queue: write at tail, read the next head with write bypass
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_queue[r_tail] <= r_tid;
        end
        if (w_wr_en && r_tail == n_head) begin
            r_head_q <= r_tid;
        end else begin
            r_head_q <= r_queue[n_head];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
        r_status  <= n_status;
        r_wvalid  <= n_wvalid;
        r_wthread <= n_wthread;
        r_depth   <= rmfh_pkg::DEPTH_W'(n_count);
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_woken_valid  = r_wvalid;
    assign o_woken_thread = r_wthread;
    assign o_lock_depth   = r_depth;

    // Checks
    `RMFH_ASSERT_NOW(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= QUEUE_MAX,
        "wait queue count above its depth")
    `RMFH_ASSERT_NOW(a_free_clean, i_clk, i_rst_n, !r_held,
        r_owner == '0 && r_count == '0 && r_used == '0, "free mutex carries owner state")
    `RMFH_ASSERT_NOW(a_held_depth, i_clk, i_rst_n, r_held, r_count != '0,
        "held mutex with zero nesting")
    `RMFH_ASSERT_NOW(a_wake_status, i_clk, i_rst_n, o_done && o_woken_valid,
        o_status == rmfh_pkg::ST_RELEASED && o_lock_depth == rmfh_pkg::DEPTH_W'(1),
        "handoff without release status or depth one")
    `RMFH_ASSERT_NEXT(a_handoff_owner, i_clk, i_rst_n, n_wvalid,
        r_held && r_owner == r_wthread, "woken thread is not the new owner")

endmodule
